/* hdl/assert_macros.svh */
// Assertion macros shared by the sampler RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_PROP(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("property violated");
`define ASSERT_NEVER(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rstn, prop)
`define ASSERT_NEVER(label, clk, rstn, cond)
`endif
`endif

/* hdl/rbs_pkg.sv */
// Constants, codes and helpers of the raster bilinear sampler.
// No dependencies; used by raster_bilinear_sampler.
`default_nettype none

package rbs_pkg;

    // raster store size (columns x rows)
    localparam int MAX_COLUMNS = 256;
    localparam int MAX_ROWS    = 256;

    // four banks split by column and row parity
    localparam int HALF_COLS  = (MAX_COLUMNS + 1) / 2;
    localparam int HALF_ROWS  = (MAX_ROWS + 1) / 2;
    localparam int BANK_DEPTH = HALF_COLS * HALF_ROWS;
    localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int NUM_BANKS  = 4;

    localparam int COL_W = $clog2(MAX_COLUMNS);
    localparam int ROW_W = $clog2(MAX_ROWS);

    localparam int VALUE_W = 32;
    localparam int SIZE_W  = 9;
    localparam int FRAC_W  = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic signed [VALUE_W-1:0] ONE_Q16 = 32'sh0001_0000;
    localparam int RASTER_SIZE_RESET = 256;

    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_SAMPLE = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X      = 3'd0,
        CFG_ORIGIN_Y      = 3'd1,
        CFG_INV_WIDTH     = 3'd2,
        CFG_INV_HEIGHT    = 3'd3,
        CFG_RASTER_WIDTH  = 3'd4,
        CFG_RASTER_HEIGHT = 3'd5,
        CFG_NO_DATA_EN    = 3'd6,
        CFG_NO_DATA_VALUE = 3'd7
    } cfg_index_t;

    // word address of a cell inside its bank
    function automatic logic [BANK_AW-1:0] bank_addr(
        input logic [BANK_AW-1:0] row_half,
        input logic [BANK_AW-1:0] col_half
    );
        return BANK_AW'(row_half * BANK_AW'(HALF_COLS)) + col_half;
    endfunction

endpackage

`default_nettype wire

/* hdl/rbs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rbs_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* hdl/raster_bilinear_sampler.sv */
// Raster bilinear sampler (uses rbs_pkg, rbs_ram, assert_macros.svh). Every input transfer
// carries either a cell load (s_tuser = 0) or a query point (s_tuser = 1); one item is taken
// in every clock cycle while the skid entry is empty, and each query gives one result, while
// loads give none. The pipeline has seven stages: offset, multiply by the inverse cell size,
// cell index and bounds check, read of the four parity banks (column and row parity, so
// all four neighbours come out of one read), two blend multiplies, the first blend add, and
// the final multiply and add. A two-entry output stage (register and skid) lets the
// pipeline keep moving while one result waits. The raster store is not cleared after reset:
// load every cell a query can touch before sampling it. Configuration may be written only
// while no item is in flight.
`default_nettype none
`include "assert_macros.svh"

module raster_bilinear_sampler (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration write channel
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // cell_column[7:0], cell_row[15:8], cell_value[47:16], point_x[79:48], point_y[111:80]
    input  logic [111:0] s_tdata,
    // op[0]
    input  logic         s_tuser,
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // sample_value[31:0]
    output logic [31:0]  m_tdata,
    // sample_valid[0]
    output logic         m_tuser
);

    localparam int VW = rbs_pkg::VALUE_W;
    localparam int FW = rbs_pkg::FRAC_W;

    typedef struct packed {
        logic [7:0]    col;
        logic [7:0]    row;
        logic [VW-1:0] value;
    } load_t;

    typedef struct packed {
        rbs_pkg::op_t      op;
        load_t             ld;
        logic signed [32:0] dx;
        logic signed [32:0] dy;
    } s1_t;

    typedef struct packed {
        rbs_pkg::op_t      op;
        load_t             ld;
        logic signed [64:0] px;
        logic signed [64:0] py;
    } s2_t;

    typedef struct packed {
        rbs_pkg::op_t                op;
        load_t                       ld;
        logic                        in_range;
        logic [rbs_pkg::COL_W-1:0]   c0;
        logic [rbs_pkg::ROW_W-1:0]   r0;
        logic [FW-1:0]               fx;
        logic [FW-1:0]               fy;
    } s3_t;

    typedef struct packed {
        logic          in_range;
        logic          c0_odd;
        logic          r0_odd;
        logic [FW-1:0] fx;
        logic [FW-1:0] fy;
    } s4_t;

    typedef struct packed {
        logic               ok;
        logic signed [VW-1:0] v00;
        logic signed [VW-1:0] v01;
        logic signed [49:0] pt;
        logic signed [49:0] pb;
        logic [FW-1:0]      fy;
    } s5_t;

    typedef struct packed {
        logic                 ok;
        logic signed [VW-1:0] top;
        logic signed [VW-1:0] bot;
        logic [FW-1:0]        fy;
    } s6_t;

    typedef struct packed {
        logic                 ok;
        logic signed [VW-1:0] top;
        logic signed [49:0]   pf;
    } s7_t;

    typedef struct packed {
        logic          flag;
        logic [VW-1:0] value;
    } result_t;

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic signed [VW-1:0]           origin_x_reg;
    logic signed [VW-1:0]           origin_y_reg;
    logic signed [VW-1:0]           inv_width_reg;
    logic signed [VW-1:0]           inv_height_reg;
    logic [rbs_pkg::SIZE_W-1:0]     raster_width_reg;
    logic [rbs_pkg::SIZE_W-1:0]     raster_height_reg;
    logic                           no_data_en_reg;
    logic [VW-1:0]                  no_data_value_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg      <= '0;
            origin_y_reg      <= '0;
            inv_width_reg     <= rbs_pkg::ONE_Q16;
            inv_height_reg    <= rbs_pkg::ONE_Q16;
            raster_width_reg  <= rbs_pkg::SIZE_W'(rbs_pkg::RASTER_SIZE_RESET);
            raster_height_reg <= rbs_pkg::SIZE_W'(rbs_pkg::RASTER_SIZE_RESET);
            no_data_en_reg    <= 1'b0;
            no_data_value_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                rbs_pkg::CFG_ORIGIN_X:      origin_x_reg      <= cfg_data;
                rbs_pkg::CFG_ORIGIN_Y:      origin_y_reg      <= cfg_data;
                rbs_pkg::CFG_INV_WIDTH:     inv_width_reg     <= cfg_data;
                rbs_pkg::CFG_INV_HEIGHT:    inv_height_reg    <= cfg_data;
                rbs_pkg::CFG_RASTER_WIDTH:  raster_width_reg  <= cfg_data[rbs_pkg::SIZE_W-1:0];
                rbs_pkg::CFG_RASTER_HEIGHT: raster_height_reg <= cfg_data[rbs_pkg::SIZE_W-1:0];
                rbs_pkg::CFG_NO_DATA_EN:    no_data_en_reg    <= cfg_data[0];
                rbs_pkg::CFG_NO_DATA_VALUE: no_data_value_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // size in use, limited to the store
    logic [rbs_pkg::SIZE_W-1:0] width_eff;
    logic [rbs_pkg::SIZE_W-1:0] height_eff;

    always_comb begin
        if (32'(raster_width_reg) > 32'(rbs_pkg::MAX_COLUMNS)) begin
            width_eff = rbs_pkg::SIZE_W'(rbs_pkg::MAX_COLUMNS);
        end else begin
            width_eff = raster_width_reg;
        end
        if (32'(raster_height_reg) > 32'(rbs_pkg::MAX_ROWS)) begin
            height_eff = rbs_pkg::SIZE_W'(rbs_pkg::MAX_ROWS);
        end else begin
            height_eff = raster_height_reg;
        end
    end

    // ---------------------------------------------------------------
    // pipeline control
    // ---------------------------------------------------------------
    logic       pipe_en;
    logic [7:1] vld_reg;
    logic       skid_valid_reg;

    // the whole pipeline advances unless the skid entry is occupied
    assign pipe_en  = !skid_valid_reg;
    assign s_tready = pipe_en;

    s1_t s1_reg, s1_next;
    s2_t s2_reg, s2_next;
    s3_t s3_reg, s3_next;
    s4_t s4_reg, s4_next;
    s5_t s5_reg, s5_next;
    s6_t s6_reg, s6_next;
    s7_t s7_reg, s7_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (pipe_en) begin
            vld_reg[1] <= s_tvalid;
            vld_reg[2] <= vld_reg[1];
            vld_reg[3] <= vld_reg[2];
            // loads end at the store; only samples go on
            vld_reg[4] <= vld_reg[3] && (s3_reg.op == rbs_pkg::OP_SAMPLE);
            vld_reg[5] <= vld_reg[4];
            vld_reg[6] <= vld_reg[5];
            vld_reg[7] <= vld_reg[6];
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
            s4_reg <= s4_next;
            s5_reg <= s5_next;
            s6_reg <= s6_next;
            s7_reg <= s7_next;
        end
    end

    // stage 1: offset from the raster origin
    always_comb begin
        s1_next.op       = rbs_pkg::op_t'(s_tuser);
        s1_next.ld.col   = s_tdata[7:0];
        s1_next.ld.row   = s_tdata[15:8];
        s1_next.ld.value = s_tdata[47:16];
        s1_next.dx = $signed({s_tdata[79], s_tdata[79:48]})
                   - $signed({origin_x_reg[VW-1], origin_x_reg});
        s1_next.dy = $signed({s_tdata[111], s_tdata[111:80]})
                   - $signed({origin_y_reg[VW-1], origin_y_reg});
    end

    // stage 2: scale to cells, exact Q32.32
    always_comb begin
        s2_next.op = s1_reg.op;
        s2_next.ld = s1_reg.ld;
        s2_next.px = s1_reg.dx * inv_width_reg;
        s2_next.py = s1_reg.dy * inv_height_reg;
    end

    // stage 3: floor to Q16.16, shift by half a cell, split index and fraction
    logic signed [64:0] cx;
    logic signed [64:0] cy;
    logic [48:0]        c0_full;
    logic [48:0]        r0_full;

    always_comb begin
        cx      = (s2_reg.px >>> FW) - 65'sd32768;
        cy      = (s2_reg.py >>> FW) - 65'sd32768;
        c0_full = cx[64:16];
        r0_full = cy[64:16];
        s3_next.op = s2_reg.op;
        s3_next.ld = s2_reg.ld;
        // both neighbours of each axis must lie inside the size in use
        s3_next.in_range = !c0_full[48] && ((c0_full + 49'd1) < 49'(width_eff))
                        && !r0_full[48] && ((r0_full + 49'd1) < 49'(height_eff));
        s3_next.c0 = cx[FW +: rbs_pkg::COL_W];
        s3_next.r0 = cy[FW +: rbs_pkg::ROW_W];
        s3_next.fx = cx[FW-1:0];
        s3_next.fy = cy[FW-1:0];
    end

    // stage 4: store write for loads, four-bank read for samples
    logic [rbs_pkg::COL_W-1:0]   col_half [2];
    logic [rbs_pkg::ROW_W-1:0]   row_half [2];
    logic [rbs_pkg::BANK_AW-1:0] rd_addr [rbs_pkg::NUM_BANKS];
    logic [VW-1:0]               rd_data [rbs_pkg::NUM_BANKS];
    logic [rbs_pkg::BANK_AW-1:0] wr_addr;
    logic [1:0]                  wr_bank;
    logic                        wr_ok;

    always_comb begin
        // even bank holds c0 when c0 is even, else c0 + 1
        col_half[0] = (s3_reg.c0 >> 1) + rbs_pkg::COL_W'(s3_reg.c0[0]);
        col_half[1] = s3_reg.c0 >> 1;
        row_half[0] = (s3_reg.r0 >> 1) + rbs_pkg::ROW_W'(s3_reg.r0[0]);
        row_half[1] = s3_reg.r0 >> 1;

        wr_addr = rbs_pkg::bank_addr(rbs_pkg::BANK_AW'(s3_reg.ld.row >> 1),
                                     rbs_pkg::BANK_AW'(s3_reg.ld.col >> 1));
        wr_bank = {s3_reg.ld.row[0], s3_reg.ld.col[0]};
        // drop loads outside the store
        wr_ok = pipe_en && vld_reg[3] && (s3_reg.op == rbs_pkg::OP_LOAD)
             && (32'(s3_reg.ld.col) < 32'(rbs_pkg::MAX_COLUMNS))
             && (32'(s3_reg.ld.row) < 32'(rbs_pkg::MAX_ROWS));

        s4_next.in_range = s3_reg.in_range;
        s4_next.c0_odd   = s3_reg.c0[0];
        s4_next.r0_odd   = s3_reg.r0[0];
        s4_next.fx       = s3_reg.fx;
        s4_next.fy       = s3_reg.fy;
    end

    // bank index is {row parity, column parity}
    for (genvar b = 0; b < rbs_pkg::NUM_BANKS; b++) begin : g_bank
        assign rd_addr[b] = rbs_pkg::bank_addr(rbs_pkg::BANK_AW'(row_half[b / 2]),
                                               rbs_pkg::BANK_AW'(col_half[b % 2]));

        rbs_ram #(
            .WIDTH (VW),
            .DEPTH (rbs_pkg::BANK_DEPTH)
        ) u_bank (
            .clk     (aclk),
            .wr_en   (wr_ok && (wr_bank == 2'(b))),
            .wr_addr (wr_addr),
            .wr_data (s3_reg.ld.value),
            .rd_en   (pipe_en),
            .rd_addr (rd_addr[b]),
            .rd_data (rd_data[b])
        );
    end

    // stage 5: order the neighbours, no-data check, horizontal products
    logic signed [VW-1:0] v00, v10, v01, v11;
    logic signed [32:0]   d_top, d_bot;
    logic                 no_data_hit;

    always_comb begin
        v00 = rd_data[{s4_reg.r0_odd, s4_reg.c0_odd}];
        v10 = rd_data[{s4_reg.r0_odd, !s4_reg.c0_odd}];
        v01 = rd_data[{!s4_reg.r0_odd, s4_reg.c0_odd}];
        v11 = rd_data[{!s4_reg.r0_odd, !s4_reg.c0_odd}];
        no_data_hit = no_data_en_reg
                   && ((v00 == no_data_value_reg) || (v10 == no_data_value_reg)
                    || (v01 == no_data_value_reg) || (v11 == no_data_value_reg));
        d_top = 33'(v10) - 33'(v00);
        d_bot = 33'(v11) - 33'(v01);
        s5_next.ok  = s4_reg.in_range && !no_data_hit;
        s5_next.v00 = v00;
        s5_next.v01 = v01;
        s5_next.pt  = d_top * $signed({1'b0, s4_reg.fx});
        s5_next.pb  = d_bot * $signed({1'b0, s4_reg.fx});
        s5_next.fy  = s4_reg.fy;
    end

    // stage 6: top and bottom rows
    logic signed [49:0] sum_top, sum_bot;

    always_comb begin
        sum_top = 50'(s5_reg.v00) + (s5_reg.pt >>> FW);
        sum_bot = 50'(s5_reg.v01) + (s5_reg.pb >>> FW);
        s6_next.ok  = s5_reg.ok;
        s6_next.top = sum_top[VW-1:0];
        s6_next.bot = sum_bot[VW-1:0];
        s6_next.fy  = s5_reg.fy;
    end

    // stage 7: vertical product
    logic signed [32:0] d_vert;

    always_comb begin
        d_vert      = 33'(s6_reg.bot) - 33'(s6_reg.top);
        s7_next.ok  = s6_reg.ok;
        s7_next.top = s6_reg.top;
        s7_next.pf  = d_vert * $signed({1'b0, s6_reg.fy});
    end

    // final add, zero on an invalid sample
    logic signed [49:0] sum_final;
    result_t            result_next;
    logic               arrival;

    always_comb begin
        sum_final = 50'(s7_reg.top) + (s7_reg.pf >>> FW);
        result_next.flag  = s7_reg.ok;
        result_next.value = s7_reg.ok ? sum_final[VW-1:0] : '0;
    end

    assign arrival = pipe_en && vld_reg[7];

    // ---------------------------------------------------------------
    // output register and skid entry
    // ---------------------------------------------------------------
    logic    m_valid_reg;
    result_t m_out_reg;
    result_t skid_out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= arrival;
            end
        end else if (arrival) begin
            // hold the new result aside until the sink takes the current one
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                m_out_reg <= skid_out_reg;
            end else if (arrival) begin
                m_out_reg <= result_next;
            end
        end else if (arrival) begin
            skid_out_reg <= result_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_out_reg.value;
    assign m_tuser  = m_out_reg.flag;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    `ASSERT_PROP(a_skid_behind_output, aclk, aresetn, skid_valid_reg |-> m_valid_reg)
    `ASSERT_PROP(a_skid_fills_on_stall, aclk, aresetn, $rose(skid_valid_reg) |-> $past(m_valid_reg && !m_tready))
    `ASSERT_PROP(a_stall_freezes_pipe, aclk, aresetn, !pipe_en |=> $stable(vld_reg))
    `ASSERT_NEVER(a_invalid_is_zero, aclk, aresetn, m_tvalid && !m_tuser && (m_tdata != '0))

endmodule

`default_nettype wire

/* verif/raster_bilinear_sampler_test.sv */
// Self-checking testbench for raster_bilinear_sampler: cell loads and point queries in a directed run and
// in fixed and random phases of raster setup, checked against an in-bench bilinear predictor.
// Depends on rbs_pkg and the raster_bilinear_sampler RTL.
`timescale 1ns / 1ps

module raster_bilinear_sampler_test;

    localparam int SETTLE_CYCLES = 16;
    localparam int IDLE_LIMIT    = 2000;
    localparam int ITEM_GOAL     = 1150;

    typedef struct packed {
        logic [31:0] value;
        logic        valid;
    } sample_t;

    typedef struct {
        logic [31:0] org_x, org_y, inv_w, inv_h;
        logic [31:0] size_w, size_h, nd_en, nd_value;
        int          col_lo, ncols, row_lo, nrows;
        int          samples;
    } phase_plan_t;

    class bilinear_scoreboard;
        logic [31:0] cells [rbs_pkg::MAX_COLUMNS*rbs_pkg::MAX_ROWS];
        bit          loaded [rbs_pkg::MAX_COLUMNS*rbs_pkg::MAX_ROWS];
        logic [31:0] org_x = '0;
        logic [31:0] org_y = '0;
        logic [31:0] inv_w = 32'h0001_0000;
        logic [31:0] inv_h = 32'h0001_0000;
        logic [8:0]  width_cfg = 9'd256;
        logic [8:0]  height_cfg = 9'd256;
        bit          nd_enable = 1'b0;
        logic [31:0] nd_value = '0;
        sample_t     expected_samples[$];
        int          failures = 0;

        function void set_register(rbs_pkg::cfg_index_t idx, logic [31:0] data);
            case (idx)
                rbs_pkg::CFG_ORIGIN_X:      org_x = data;
                rbs_pkg::CFG_ORIGIN_Y:      org_y = data;
                rbs_pkg::CFG_INV_WIDTH:     inv_w = data;
                rbs_pkg::CFG_INV_HEIGHT:    inv_h = data;
                rbs_pkg::CFG_RASTER_WIDTH:  width_cfg = data[8:0];
                rbs_pkg::CFG_RASTER_HEIGHT: height_cfg = data[8:0];
                rbs_pkg::CFG_NO_DATA_EN:    nd_enable = data[0];
                rbs_pkg::CFG_NO_DATA_VALUE: nd_value = data;
                default: ;
            endcase
        endfunction

        // map coordinate to cell coordinate, Q16.16, half a cell back to the centre
        function longint scaled(logic [31:0] p, logic [31:0] o, logic [31:0] k);
            longint prod;
            prod = (longint'($signed(p)) - longint'($signed(o))) * longint'($signed(k));
            return (prod >>> 16) - 32768;
        endfunction

        function bit locate(logic [31:0] px, logic [31:0] py, output longint c0,
                            output longint r0, output longint fx, output longint fy);
            longint cx, cy, w, h;
            cx = scaled(px, org_x, inv_w);
            cy = scaled(py, org_y, inv_h);
            w = (width_cfg > rbs_pkg::MAX_COLUMNS) ? rbs_pkg::MAX_COLUMNS : width_cfg;
            h = (height_cfg > rbs_pkg::MAX_ROWS) ? rbs_pkg::MAX_ROWS : height_cfg;
            c0 = cx >>> 16;
            r0 = cy >>> 16;
            fx = cx & 64'hFFFF;
            fy = cy & 64'hFFFF;
            return c0 >= 0 && c0 + 1 < w && r0 >= 0 && r0 + 1 < h;
        endfunction

        function longint cell_at(longint c, longint r);
            return longint'($signed(cells[r * rbs_pkg::MAX_COLUMNS + c]));
        endfunction

        function bit cell_loaded(longint c, longint r);
            return loaded[r * rbs_pkg::MAX_COLUMNS + c];
        endfunction

        function longint blend(longint a, longint b, longint f);
            return a + (((b - a) * f) >>> 16);
        endfunction

        // true when a query would touch a cell that was never loaded
        function bit reads_unloaded(logic [31:0] px, logic [31:0] py);
            longint c0, r0, fx, fy;
            if (!locate(px, py, c0, r0, fx, fy))
                return 1'b0;
            return !(cell_loaded(c0, r0) && cell_loaded(c0 + 1, r0) &&
                     cell_loaded(c0, r0 + 1) && cell_loaded(c0 + 1, r0 + 1));
        endfunction

        function void note_input(rbs_pkg::op_t op, logic [111:0] d);
            longint  c0, r0, fx, fy, v00, v10, v01, v11, nd, top, bot;
            int      addr;
            sample_t want;
            if (op == rbs_pkg::OP_LOAD) begin
                addr = int'(d[15:8]) * rbs_pkg::MAX_COLUMNS + int'(d[7:0]);
                cells[addr] = d[47:16];
                loaded[addr] = 1'b1;
            end else begin
                want = '0;
                want.valid = locate(d[79:48], d[111:80], c0, r0, fx, fy);
                if (want.valid) begin
                    v00 = cell_at(c0, r0);
                    v10 = cell_at(c0 + 1, r0);
                    v01 = cell_at(c0, r0 + 1);
                    v11 = cell_at(c0 + 1, r0 + 1);
                    nd = longint'($signed(nd_value));
                    if (nd_enable && (v00 == nd || v10 == nd || v01 == nd || v11 == nd)) begin
                        want.valid = 1'b0;
                    end else begin
                        top = blend(v00, v10, fx);
                        bot = blend(v01, v11, fx);
                        want.value = 32'(blend(top, bot, fy));
                    end
                end
                expected_samples.push_back(want);
            end
        endfunction

        function void check_result(logic [31:0] value, logic valid);
            sample_t want;
            if (expected_samples.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("result with no query pending: value %h valid %b", value, valid);
            end else begin
                want = expected_samples.pop_front();
                if (value !== want.value || valid !== want.valid) begin
                    failures++;
                    if (failures <= 10)
                        $display("sample mismatch: expected value %h valid %b, got value %h valid %b",
                                 want.value, want.valid, value, valid);
                end
            end
        endfunction

        function int pending();
            return expected_samples.size();
        endfunction
    endclass

    logic         aclk;
    logic         aresetn = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = '0;
    logic [31:0]  cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [111:0] s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [31:0]  m_tdata;
    logic         m_tuser;

    bilinear_scoreboard sb = new;
    bit steady = 1'b0;
    int items_sent = 0;
    int idle_cycles = 0;

    raster_bilinear_sampler u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        m_tready = steady || ($urandom_range(99) >= 14);
    end

    // note every transfer and end the run if traffic stops altogether
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                sb.set_register(rbs_pkg::cfg_index_t'(cfg_index), cfg_data);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser);
            if (s_tvalid && s_tready)
                sb.note_input(rbs_pkg::op_t'(s_tuser), s_tdata);
            if ((cfg_valid && cfg_ready) || (m_tvalid && m_tready) || (s_tvalid && s_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    function automatic logic [111:0] load_word(logic [7:0] col, logic [7:0] row,
                                               logic [31:0] value);
        return {$urandom(), $urandom(), value, row, col};
    endfunction

    function automatic logic [111:0] point_word(logic [31:0] px, logic [31:0] py);
        return {py, px, $urandom(), 8'($urandom()), 8'($urandom())};
    endfunction

    function automatic logic [31:0] pick_value(logic [31:0] nd);
        int r = $urandom_range(99);
        if (r < 12)
            return nd;
        if (r < 20) begin
            case ($urandom_range(3))
                0: return 32'h7FFF_FFFF;
                1: return 32'h8000_0000;
                2: return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        if (r < 60)
            return $urandom();
        return 32'(int'($urandom_range(0, 131072000)) - 65536000);
    endfunction

    function automatic logic [8:0] pick_size();
        int r = $urandom_range(99);
        if (r < 70)
            return 9'($urandom_range(2, 16));
        if (r < 76)
            return 9'($urandom_range(0, 1));
        if (r < 88)
            return 9'd256;
        return 9'($urandom_range(257, 511));
    endfunction

    function automatic logic [31:0] pick_scale();
        int r = $urandom_range(99);
        logic [31:0] s;
        if (r < 4)
            return 32'h0;
        if (r < 12)
            return $urandom();
        if (r < 30)
            s = 32'h0001_0000;
        else
            s = $urandom_range(16384, 262144);
        return $urandom_range(1) ? -s : s;
    endfunction

    function automatic logic [31:0] pick_origin();
        int r = $urandom_range(99);
        if (r < 30)
            return 32'h0;
        if (r < 60)
            return $urandom();
        return 32'(int'($urandom_range(0, 13107200)) - 6553600);
    endfunction

    // loaded window along one axis, often flush with an edge of the raster
    function automatic void pick_window(logic [8:0] size, output int lo, output int n);
        int eff = (size > 256) ? 256 : size;
        int r = $urandom_range(2);
        n = $urandom_range(2, 8);
        if (eff < n)
            lo = 0;
        else if (r == 0)
            lo = 0;
        else if (r == 1)
            lo = eff - n;
        else
            lo = $urandom_range(eff - n);
    endfunction

    function automatic phase_plan_t random_plan();
        phase_plan_t p;
        logic [8:0] w, h;
        w = pick_size();
        h = pick_size();
        p.org_x = pick_origin();
        p.org_y = pick_origin();
        p.inv_w = pick_scale();
        p.inv_h = pick_scale();
        p.size_w = ($urandom() & ~32'h1FF) | 32'(w);
        p.size_h = ($urandom() & ~32'h1FF) | 32'(h);
        p.nd_en = ($urandom() & ~32'h1) | 32'($urandom_range(1));
        p.nd_value = pick_value(32'h0);
        pick_window(w, p.col_lo, p.ncols);
        pick_window(h, p.row_lo, p.nrows);
        p.samples = $urandom_range(60, 140);
        return p;
    endfunction

    // map coordinate that lands near the loaded window; exact centres now and then
    function automatic logic [31:0] aim(int lo, int n, logic [31:0] org, logic [31:0] inv);
        real t, p;
        if (inv == 0)
            return $urandom();
        if ($urandom_range(3) == 0)
            t = $itor($urandom_range(n + 1)) + lo - 1;
        else
            t = lo - 1.5 + (n + 2.0) * $urandom_range(65535) / 65536.0;
        p = $itor($signed(org)) + (t + 0.5) * 4294967296.0 / $itor($signed(inv));
        if (p > 2147483647.0)
            p = 2147483647.0;
        if (p < -2147483648.0)
            p = -2147483648.0;
        return 32'(longint'(p));
    endfunction

    task automatic push_item(rbs_pkg::op_t op, logic [111:0] data);
        while (!steady && $urandom_range(99) < 14)
            @(negedge aclk);
        s_tuser = op;
        s_tdata = data;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        s_tvalid = 1'b0;
        items_sent++;
    endtask

    task automatic load_cell(logic [7:0] col, logic [7:0] row, logic [31:0] value);
        push_item(rbs_pkg::OP_LOAD, load_word(col, row, value));
    endtask

    task automatic sample_at(logic [31:0] px, logic [31:0] py);
        push_item(rbs_pkg::OP_SAMPLE, point_word(px, py));
    endtask

    task automatic write_register(rbs_pkg::cfg_index_t idx, logic [31:0] data);
        cfg_index = idx;
        cfg_data = data;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // hold until every query has answered, then let trailing loads leave the pipeline
    task automatic wait_quiet();
        while (sb.pending() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic run_directed();
        load_cell(8'd0, 8'd0, 32'h7FFF_FFFF);
        load_cell(8'd1, 8'd0, 32'h8000_0000);
        load_cell(8'd0, 8'd1, 32'h0000_0000);
        load_cell(8'd1, 8'd1, 32'hFFFF_FFFF);
        load_cell(8'd254, 8'd254, 32'h0012_3456);
        load_cell(8'd255, 8'd254, 32'hFFED_CBA9);
        load_cell(8'd254, 8'd255, 32'h8000_0000);
        load_cell(8'd255, 8'd255, 32'h7FFF_FFFF);
        sample_at(32'h0000_8000, 32'h0000_8000);
        sample_at(32'h0001_0000, 32'h0001_0000);
        sample_at(32'h0001_7FFF, 32'h0000_8000);
        sample_at(32'h0000_8000, 32'h0001_7FFF);
        // just left of the first centre: index -1
        sample_at(32'h0000_7FFF, 32'h0000_8000);
        sample_at(32'h00FF_7FFF, 32'h00FF_7FFF);
        // last column with zero weight still falls off the raster
        sample_at(32'h00FF_8000, 32'h00FF_7FFF);
        sample_at(32'h00FF_7FFF, 32'h00FF_8000);
        sample_at(32'h7FFF_FFFF, 32'h8000_0000);
        sample_at(32'h8000_0000, 32'h7FFF_FFFF);
        // overwrite and read back at once
        load_cell(8'd0, 8'd0, 32'h0001_0000);
        sample_at(32'h0000_8000, 32'h0000_8000);
        sample_at(32'h0000_C000, 32'h0000_C000);
    endtask

    task automatic run_phase(phase_plan_t plan);
        logic [31:0] px, py;
        int          k, r, c, tries;
        bit          placed;
        wait_quiet();
        write_register(rbs_pkg::CFG_ORIGIN_X, plan.org_x);
        write_register(rbs_pkg::CFG_ORIGIN_Y, plan.org_y);
        write_register(rbs_pkg::CFG_INV_WIDTH, plan.inv_w);
        write_register(rbs_pkg::CFG_INV_HEIGHT, plan.inv_h);
        write_register(rbs_pkg::CFG_RASTER_WIDTH, plan.size_w);
        write_register(rbs_pkg::CFG_RASTER_HEIGHT, plan.size_h);
        write_register(rbs_pkg::CFG_NO_DATA_EN, plan.nd_en);
        write_register(rbs_pkg::CFG_NO_DATA_VALUE, plan.nd_value);
        for (r = 0; r < plan.nrows; r++)
            for (c = 0; c < plan.ncols; c++)
                load_cell(8'(plan.col_lo + c), 8'(plan.row_lo + r), pick_value(plan.nd_value));
        for (k = 0; k < plan.samples; k++) begin
            if (k == plan.samples / 2)
                wait_quiet();
            r = $urandom_range(99);
            placed = 1'b0;
            if (r >= 12) begin
                if (r < 17) begin
                    px = $urandom();
                    py = $urandom();
                    placed = !sb.reads_unloaded(px, py);
                end
                for (tries = 0; tries < 8 && !placed; tries++) begin
                    px = aim(plan.col_lo, plan.ncols, plan.org_x, plan.inv_w);
                    py = aim(plan.row_lo, plan.nrows, plan.org_y, plan.inv_h);
                    placed = !sb.reads_unloaded(px, py);
                end
            end
            if (placed)
                sample_at(px, py);
            else
                load_cell(8'(plan.col_lo + $urandom_range(plan.ncols - 1)),
                          8'(plan.row_lo + $urandom_range(plan.nrows - 1)),
                          pick_value(plan.nd_value));
        end
    endtask

    initial begin
        phase_plan_t plan;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        run_directed();

        // extreme origins and scales, sizes past the store, no-data at the most negative value
        plan = '{org_x: 32'h8000_0000, org_y: 32'h7FFF_FFFF, inv_w: 32'h7FFF_FFFF,
                 inv_h: 32'h8000_0000, size_w: 32'h0000_01FF, size_h: 32'h0000_012C,
                 nd_en: 32'h1, nd_value: 32'h8000_0000, col_lo: 250, ncols: 6,
                 row_lo: 0, nrows: 4, samples: 40};
        run_phase(plan);

        // zero scale and zero width: nothing may come back valid
        plan = '{org_x: 32'h7FFF_FFFF, org_y: 32'h8000_0000, inv_w: 32'h0,
                 inv_h: 32'h0001_0000, size_w: 32'h0, size_h: 32'h0000_0100,
                 nd_en: 32'h0, nd_value: 32'h7FFF_FFFF, col_lo: 0, ncols: 2,
                 row_lo: 0, nrows: 2, samples: 24};
        run_phase(plan);

        // smallest usable raster, rows flipped, zero as no-data
        plan = '{org_x: 32'h0, org_y: 32'h0, inv_w: 32'h0001_0000, inv_h: 32'hFFFF_0000,
                 size_w: 32'h2, size_h: 32'h2, nd_en: 32'h1, nd_value: 32'h0,
                 col_lo: 0, ncols: 2, row_lo: 0, nrows: 2, samples: 40};
        run_phase(plan);

        steady = 1'b1;
        run_phase(random_plan());
        steady = 1'b0;

        while (items_sent < ITEM_GOAL)
            run_phase(random_plan());

        wait_quiet();
        if (sb.failures == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
